@@ rtl/ubd_pkg.sv @@
// ----------------------------------------------------------------------------
// ubd_pkg
// types, constants and the prescaler shift function shared by the baud divisor block
// ----------------------------------------------------------------------------
package ubd_pkg;

    typedef struct packed {
        logic [23:0] baud_rate;
        logic        use_fast_bus;
    } ubd_in_t;

    typedef struct packed {
        logic [15:0] divisor_word;
        logic [31:0] sysclk_hz;
        logic [31:0] bus_clock_hz;
        logic        divide_error;
    } ubd_out_t;

    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_CLOCK_CFG = 2'd0;
    localparam logic [1:0] REG_PLL_CFG   = 2'd1;
    localparam logic [1:0] REG_OVERSAMPLE = 2'd2;

    localparam logic [31:0] CLOCK_CFG_RESET = 32'h0000_0000;
    localparam logic [31:0] PLL_CFG_RESET   = 32'h2400_3010;

    localparam logic [23:0] INTERNAL_OSC_HZ = 24'd16000000;
    localparam logic [23:0] EXTERNAL_OSC_HZ = 24'd8000000;

    localparam logic [1:0] SWS_EXTERNAL = 2'd1;
    localparam logic [1:0] SWS_PLL      = 2'd2;

    localparam logic [1:0] PLL_P_DIV2 = 2'd0;
    localparam logic [1:0] PLL_P_DIV4 = 2'd1;
    localparam logic [1:0] PLL_P_DIV6 = 2'd2;

    localparam logic [31:0] RECIP_3   = 32'hAAAA_AAAB;
    localparam logic [31:0] RECIP_100 = 32'h51EB_851F;
    localparam logic [12:0] RECIP_100_SMALL = 13'd5243;

    function automatic logic [3:0] presc_shift(input logic [3:0] code);
        logic [3:0] s;
        case (code)
            4'd4:  s = 4'd1;
            4'd5:  s = 4'd2;
            4'd6:  s = 4'd3;
            4'd7:  s = 4'd4;
            4'd8:  s = 4'd1;
            4'd9:  s = 4'd2;
            4'd10: s = 4'd3;
            4'd11: s = 4'd4;
            4'd12: s = 4'd6;
            4'd13: s = 4'd7;
            4'd14: s = 4'd8;
            4'd15: s = 4'd9;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/ubd_div_cell.sv @@
// ----------------------------------------------------------------------------
// ubd_div_cell
// one restoring division step, registered, with its own beat handshake
// ----------------------------------------------------------------------------
module ubd_div_cell #(
    parameter int unsigned NW = 32,
    parameter int unsigned DW = 26,
    parameter int unsigned SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [NW-1:0] work_in,
    input  logic [DW-1:0] rem_in,
    input  logic [DW-1:0] dvs_in,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [NW-1:0] work_out,
    output logic [DW-1:0] rem_out,
    output logic [DW-1:0] dvs_out,
    output logic [SW-1:0] side_out
);

    logic          valid_reg;
    logic [NW-1:0] work_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [SW-1:0] side_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [NW-1:0] work_next;
    logic [DW-1:0] rem_next;

    assign trial     = {rem_in, work_in[NW-1]};
    assign diff      = trial - {1'b0, dvs_in};
    assign ge        = trial >= {1'b0, dvs_in};
    assign rem_next  = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign work_next = {work_in[NW-2:0], ge};

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_in;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign work_out  = work_reg;
    assign rem_out   = rem_reg;
    assign dvs_out   = dvs_reg;
    assign side_out  = side_reg;

endmodule

@@ rtl/ubd_div_chain.sv @@
// ----------------------------------------------------------------------------
// ubd_div_chain
// row of division cells, one quotient bit per cell, msb first
// ----------------------------------------------------------------------------
module ubd_div_chain #(
    parameter int unsigned NW = 32,
    parameter int unsigned DW = 26,
    parameter int unsigned SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [NW-1:0] quotient,
    output logic [SW-1:0] side_out
);

    logic          vld [NW+1];
    logic          rdy [NW+1];
    logic [NW-1:0] wrk [NW+1];
    logic [DW-1:0] rem [NW+1];
    logic [DW-1:0] dvs [NW+1];
    logic [SW-1:0] sid [NW+1];

    assign vld[0]   = in_valid;
    assign in_ready = rdy[0];
    assign wrk[0]   = dividend;
    assign rem[0]   = '0;
    assign dvs[0]   = divisor;
    assign sid[0]   = side_in;

    for (genvar i = 0; i < NW; i++) begin : g_cell
        ubd_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .work_in   (wrk[i]),
            .rem_in    (rem[i]),
            .dvs_in    (dvs[i]),
            .side_in   (sid[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .work_out  (wrk[i+1]),
            .rem_out   (rem[i+1]),
            .dvs_out   (dvs[i+1]),
            .side_out  (sid[i+1])
        );
    end

    assign rdy[NW]   = out_ready;
    assign out_valid = vld[NW];
    assign quotient  = wrk[NW];
    assign side_out  = sid[NW];

endmodule

@@ rtl/usart_baud_divisor_from_clock_tree.sv @@
// ----------------------------------------------------------------------------
// usart_baud_divisor_from_clock_tree
// usart fractional baud divisor derived from the clock tree configuration
// ----------------------------------------------------------------------------
// Takes one request beat per clock unless back-pressure from m_ready stalls
// the pipe. The datapath is built from two chains of restoring-division
// cells: 24 cells dividing the pll source clock by M, and 32 cells dividing
// the scaled bus clock by the oversampled baud rate, plus five arithmetic
// stages. Every stage holds its beat under back-pressure, so bubbles are
// filled while a result waits. Configuration registers sit behind an apb
// port at byte addresses 0, 4 and 8 and must be written while idle.
// ----------------------------------------------------------------------------
module usart_baud_divisor_from_clock_tree (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ubd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ubd_pkg::ubd_in_t            s_payload,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ubd_pkg::ubd_out_t           m_payload
);

    // configuration registers
    logic [31:0] clock_cfg_reg;
    logic [31:0] pll_cfg_reg;
    logic        os8_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_cfg_reg <= ubd_pkg::CLOCK_CFG_RESET;
            pll_cfg_reg   <= ubd_pkg::PLL_CFG_RESET;
            os8_reg       <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                ubd_pkg::REG_CLOCK_CFG:  clock_cfg_reg <= pwdata;
                ubd_pkg::REG_PLL_CFG:    pll_cfg_reg   <= pwdata;
                ubd_pkg::REG_OVERSAMPLE: os8_reg       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ubd_pkg::REG_CLOCK_CFG:  prdata = clock_cfg_reg;
            ubd_pkg::REG_PLL_CFG:    prdata = pll_cfg_reg;
            ubd_pkg::REG_OVERSAMPLE: prdata = {31'd0, os8_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // decoded fields
    logic [1:0] sws;
    logic [5:0] pll_m;
    logic [8:0] pll_n;
    logic [1:0] pll_p;
    logic       m_zero;

    assign sws    = clock_cfg_reg[3:2];
    assign pll_m  = pll_cfg_reg[5:0];
    assign pll_n  = pll_cfg_reg[14:6];
    assign pll_p  = pll_cfg_reg[17:16];
    assign m_zero = (sws == ubd_pkg::SWS_PLL) && (pll_m == 6'd0);

    // pll source divided by m
    logic        a_valid;
    logic        a_ready;
    logic [23:0] a_quot;
    logic [24:0] a_side;

    ubd_div_chain #(.NW(24), .DW(6), .SW(25)) u_pll_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .dividend  (pll_cfg_reg[22] ? ubd_pkg::EXTERNAL_OSC_HZ : ubd_pkg::INTERNAL_OSC_HZ),
        .divisor   (pll_m),
        .side_in   (s_payload),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .quotient  (a_quot),
        .side_out  (a_side)
    );

    // vco = (src / m) * n
    logic             st1_valid_reg;
    logic [31:0]      vco_reg;
    ubd_pkg::ubd_in_t st1_req_reg;
    logic             st1_ready;
    logic [32:0]      vco_full;

    assign vco_full = a_quot * pll_n;
    assign a_ready  = !st1_valid_reg || st1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (a_ready) begin
            st1_valid_reg <= a_valid;
        end
        if (a_valid && a_ready) begin
            vco_reg     <= vco_full[31:0];
            st1_req_reg <= a_side;
        end
    end

    // sys = vco / p when the pll is selected, else the external or internal oscillator
    logic             st2_valid_reg;
    logic [31:0]      sys_reg;
    ubd_pkg::ubd_in_t st2_req_reg;
    logic             st2_ready;
    logic [63:0]      div3_prod;
    logic [31:0]      pll_sys;
    logic [31:0]      sys_next;

    assign div3_prod = {33'd0, vco_reg[31:1]} * {32'd0, ubd_pkg::RECIP_3};

    always_comb begin
        case (pll_p)
            ubd_pkg::PLL_P_DIV2: pll_sys = vco_reg >> 1;
            ubd_pkg::PLL_P_DIV4: pll_sys = vco_reg >> 2;
            ubd_pkg::PLL_P_DIV6: pll_sys = div3_prod[63:33] == 31'd0 ? 32'd0
                                          : {1'b0, div3_prod[63:33]};
            default:             pll_sys = vco_reg >> 3;
        endcase
        if (sws == ubd_pkg::SWS_PLL) begin
            sys_next = m_zero ? 32'd0 : pll_sys;
        end else if (sws == ubd_pkg::SWS_EXTERNAL) begin
            sys_next = {8'd0, ubd_pkg::EXTERNAL_OSC_HZ};
        end else begin
            sys_next = {8'd0, ubd_pkg::INTERNAL_OSC_HZ};
        end
    end

    assign st1_ready = !st2_valid_reg || st2_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (st1_ready) begin
            st2_valid_reg <= st1_valid_reg;
        end
        if (st1_valid_reg && st1_ready) begin
            sys_reg     <= sys_next;
            st2_req_reg <= st1_req_reg;
        end
    end

    // bus clock, scaled clock and oversampled divisor
    typedef struct packed {
        logic [31:0] sys;
        logic [31:0] bus;
        logic        baud_zero;
        logic        err;
    } side_b_t;

    logic        st3_valid_reg;
    logic [31:0] scaled_reg;
    logic [25:0] dvs_reg;
    side_b_t     st3_side_reg;
    logic        st3_ready;
    logic [31:0] hclk;
    logic [31:0] pclk1;
    logic [31:0] pclk2;
    logic [31:0] bus;
    side_b_t     st3_side_next;

    assign hclk  = sys_reg >> ubd_pkg::presc_shift(clock_cfg_reg[7:4]);
    assign pclk1 = hclk >> ubd_pkg::presc_shift({1'b0, clock_cfg_reg[12:10]});
    assign pclk2 = hclk >> ubd_pkg::presc_shift({1'b0, clock_cfg_reg[15:13]});
    assign bus   = st2_req_reg.use_fast_bus ? pclk2 : pclk1;

    always_comb begin
        st3_side_next.sys       = sys_reg;
        st3_side_next.bus       = bus;
        st3_side_next.baud_zero = st2_req_reg.baud_rate == 24'd0;
        st3_side_next.err       = m_zero;
    end

    assign st2_ready = !st3_valid_reg || st3_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_valid_reg <= 1'b0;
        end else if (st2_ready) begin
            st3_valid_reg <= st2_valid_reg;
        end
        if (st2_valid_reg && st2_ready) begin
            scaled_reg   <= (bus << 4) + (bus << 3) + bus;
            dvs_reg      <= os8_reg ? {1'b0, st2_req_reg.baud_rate, 1'b0}
                                    : {st2_req_reg.baud_rate, 2'b00};
            st3_side_reg <= st3_side_next;
        end
    end

    // scaled clock divided by oversampled baud rate
    logic        b_valid;
    logic        b_ready;
    logic [31:0] b_quot;
    side_b_t     b_side;

    ubd_div_chain #(.NW(32), .DW(26), .SW($bits(side_b_t))) u_baud_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (st3_valid_reg),
        .in_ready  (st3_ready),
        .dividend  (scaled_reg),
        .divisor   (dvs_reg),
        .side_in   (st3_side_reg),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .quotient  (b_quot),
        .side_out  (b_side)
    );

    // mantissa = idiv / 100
    logic        st4_valid_reg;
    logic [26:0] mant_reg;
    logic [31:0] idiv_reg;
    side_b_t     st4_side_reg;
    logic        st4_ready;
    logic [63:0] mant_prod;

    assign mant_prod = {32'd0, b_quot} * {32'd0, ubd_pkg::RECIP_100};
    assign b_ready   = !st4_valid_reg || st4_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st4_valid_reg <= 1'b0;
        end else if (b_ready) begin
            st4_valid_reg <= b_valid;
        end
        if (b_valid && b_ready) begin
            mant_reg     <= mant_prod[63:37];
            idiv_reg     <= b_quot;
            st4_side_reg <= b_side;
        end
    end

    // rounded fraction and output register
    logic              out_valid_reg;
    ubd_pkg::ubd_out_t out_reg;
    ubd_pkg::ubd_out_t out_next;
    logic [6:0]        frac;
    logic [10:0]       frac_sc;
    logic [23:0]       frac_prod;
    logic [3:0]        frac_rnd;

    always_comb begin
        frac      = idiv_reg[6:0] - (mant_reg[6:0] * 7'd100);
        frac_sc   = (os8_reg ? {1'b0, frac, 3'd0} : {frac, 4'd0}) + 11'd50;
        frac_prod = frac_sc * ubd_pkg::RECIP_100_SMALL;
        frac_rnd  = os8_reg ? {1'b0, frac_prod[21:19]} : frac_prod[22:19];
        out_next.divisor_word = st4_side_reg.baud_zero ? 16'd0 : {mant_reg[11:0], frac_rnd};
        out_next.sysclk_hz    = st4_side_reg.sys;
        out_next.bus_clock_hz = st4_side_reg.bus;
        out_next.divide_error = st4_side_reg.err || st4_side_reg.baud_zero;
    end

    assign st4_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (st4_ready) begin
            out_valid_reg <= st4_valid_reg;
        end
        if (st4_valid_reg && st4_ready) begin
            out_reg <= out_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule
